// ----- sv/sfbl_pkg.sv -----
// ----------------------------------------------------------------------------
// sfbl_pkg
// Shared constants and types for the SysEx firmware block loader.
// ----------------------------------------------------------------------------
package sfbl_pkg;

    localparam int unsigned MAX_PAGE_BYTES = 1024;
    localparam int unsigned CHUNK_BYTES    = 32;
    localparam int unsigned BLOCK_LEN      = 70;
    localparam int unsigned ROWS           = MAX_PAGE_BYTES / CHUNK_BYTES;
    localparam int unsigned ROW_W          = $clog2(ROWS);

    localparam logic [7:0] SYX_START  = 8'hF0;
    localparam logic [7:0] SYX_END    = 8'hF7;
    localparam logic [7:0] HDR_ID1    = 8'h6F;
    localparam logic [7:0] HDR_ID2    = 8'h6B;
    localparam logic [7:0] HDR_FLASH  = 8'h5F;
    localparam logic [7:0] HDR_RESET  = 8'h21;
    localparam logic [7:0] STATUS_BIT = 8'h80;

    localparam logic [3:0] LG_MIN   = 4'd6;
    localparam logic [3:0] LG_MAX   = 4'd10;
    localparam logic [3:0] LG_CHUNK = 4'd5;

    // register addresses
    localparam logic [2:0] REG_PAGE_SIZE_LOG2 = 3'd0;

    typedef enum logic [2:0] {
        KIND_STATUS  = 3'd0,
        KIND_ENTER   = 3'd1,
        KIND_CHUNK   = 3'd2,
        KIND_RETURN  = 3'd3,
        KIND_SW_RST  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_IGNORE = 2'd2
    } mode_t;

endpackage

// ----- sv/sfbl_if.sv -----
// ----------------------------------------------------------------------------
// sfbl channel interfaces
// Byte input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfbl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface sfbl_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [21:0] page_address;
    logic [4:0]  chunk_index;
    logic [63:0] chunk_bytes_0_7;
    logic [63:0] chunk_bytes_8_15;
    logic [63:0] chunk_bytes_16_23;
    logic [63:0] chunk_bytes_24_31;
    logic        active;
    logic        last;

    modport source (output valid, output kind, output page_address, output chunk_index,
                    output chunk_bytes_0_7, output chunk_bytes_8_15,
                    output chunk_bytes_16_23, output chunk_bytes_24_31,
                    output active, output last, input ready);
    modport sink   (input valid, input kind, input page_address, input chunk_index,
                    input chunk_bytes_0_7, input chunk_bytes_8_15,
                    input chunk_bytes_16_23, input chunk_bytes_24_31,
                    input active, input last, output ready);
endinterface

// ----- sv/sysex_firmware_block_loader_top.sv -----
// ----------------------------------------------------------------------------
// sysex_firmware_block_loader_top
// Parses SysEx flashing messages, checks 70-byte blocks and streams pages.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  midi    | in  | valid/ready       | data_byte[7:0]
//  result  | out | valid/ready       | kind, page_address, chunk_index, 4x64b bytes,
//          |     |                   | active, last (status item is last per byte)
//  apb     | in  | psel/penable      | page_size_log2 at byte address 0
//
// A byte that only updates state is accepted, then answered with a status item.
// The eighth byte of an unpack group starts the checksum: the Fletcher-16 unit
// takes one unpacked byte per cycle. Each chunk flushed after a completed block
// goes through a page memory read, then the output register.
// Reset clears all control state; page memory contents are masked by row
// valid bits. A stalled result only freezes the sequencer; midi.ready is high
// only while the sequencer is idle.
module sysex_firmware_block_loader_top (
    input  logic                  clk,
    input  logic                  rst_n,
    sfbl_byte_if.sink             midi,
    sfbl_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import sfbl_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SUM    = 14'b00000000000010,
        S_CHECK  = 14'b00000000000100,
        S_ABORT  = 14'b00000000001000,
        S_ENTER  = 14'b00000000010000,
        S_PLACE  = 14'b00000000100000,
        S_OPEN   = 14'b00000001000000,
        S_WR0    = 14'b00000010000000,
        S_WR1    = 14'b00000100000000,
        S_FL_RD  = 14'b00001000000000,
        S_FL_EM  = 14'b00010000000000,
        S_RET    = 14'b00100000000000,
        S_RST    = 14'b01000000000000,
        S_STATUS = 14'b10000000000000
    } state_t;

    localparam int unsigned BLK_W = BLOCK_LEN * 8;

    // ---------------- registers ----------------
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic                ff_reg, ff_next;          // flashing session open
    logic [2:0]          hc_reg, hc_next;          // header byte count
    logic [7:0]          h1_reg, h1_next;
    logic [7:0]          h2_reg, h2_next;
    logic [2:0]          uc_reg, uc_next;          // unpack count
    logic [7:0]          unpack_reg [7];
    logic [7:0]          unpack_next [7];
    logic [2:0]          step_reg, step_next;
    logic [7:0]          s1_reg, s1_next;
    logic [7:0]          s2_reg, s2_next;
    logic [6:0]          bf_reg, bf_next;          // block fill
    logic [BLK_W-1:0]    blk_reg, blk_next;        // block shift line, byte 0 at LSB
    logic [16:0]         eid_reg, eid_next;
    logic                tib_reg, tib_next;        // target in bootloader
    logic [3:0]          lg_reg, lg_next;          // latched page size log2
    logic [21:0]         pbase_reg, pbase_next;
    logic                popen_reg, popen_next;
    logic [ROWS-1:0]     rowv_reg, rowv_next;
    logic [ROW_W-1:0]    k_reg, k_next;            // flush chunk counter
    logic                cont_open_reg, cont_open_next;
    logic                rst_pend_reg, rst_pend_next;
    logic [3:0]          cfg_reg;

    // output register
    logic                ov_reg;
    kind_t               okind_reg;
    logic [21:0]         oaddr_reg;
    logic [4:0]          oidx_reg;
    logic [255:0]        odata_reg;
    logic                oact_reg;
    logic                olast_reg;

    // page memory, one 32-byte chunk per row
    logic [255:0]        page_mem [ROWS];
    logic [255:0]        mem_q;
    logic                rv_q;

    // ---------------- emit interface ----------------
    logic                out_free;
    logic                emit_req;
    kind_t               emit_kind;
    logic                fire;

    assign out_free = !ov_reg || result.ready;
    assign fire     = emit_req && out_free;

    // ---------------- datapath helpers ----------------
    logic [7:0]          b;
    logic [7:0]          sbyte;
    logic [8:0]          s1_sum, s2_sum;
    logic [7:0]          s1_mod, s2_mod;
    logic [15:0]         blk_id, blk_a16;
    logic [21:0]         blk_addr, blk_base, blk_off;
    logic [ROW_W-1:0]    wr_row;
    logic [ROW_W-1:0]    last_k;
    logic [3:0]          lg_clamped;
    logic                cfg_wr;

    assign b        = midi.data_byte;
    assign sbyte    = unpack_reg[step_reg];
    assign s1_sum   = {1'b0, s1_reg} + {1'b0, sbyte};
    assign s1_mod   = (s1_sum >= 9'd255) ? 8'(s1_sum - 9'd255) : s1_sum[7:0];
    assign s2_sum   = {1'b0, s2_reg} + {1'b0, s1_mod};
    assign s2_mod   = (s2_sum >= 9'd255) ? 8'(s2_sum - 9'd255) : s2_sum[7:0];

    assign blk_id   = blk_reg[64*8 +: 16];
    assign blk_a16  = blk_reg[66*8 +: 16];
    assign blk_addr = {blk_a16, 6'd0};
    assign blk_base = blk_addr & (22'h3FFFFF << lg_reg);
    assign blk_off  = blk_addr & ~(22'h3FFFFF << lg_reg);
    assign wr_row   = blk_off[ROW_W+4:5];
    assign last_k   = ROW_W'((6'd1 << (lg_reg - LG_CHUNK)) - 6'd1);

    assign lg_clamped = (cfg_reg < LG_MIN) ? LG_MIN : ((cfg_reg > LG_MAX) ? LG_MAX : cfg_reg);

    assign midi.ready = (state_reg == S_IDLE);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        ff_next        = ff_reg;
        hc_next        = hc_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        uc_next        = uc_reg;
        unpack_next    = unpack_reg;
        step_next      = step_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        bf_next        = bf_reg;
        blk_next       = blk_reg;
        eid_next       = eid_reg;
        tib_next       = tib_reg;
        lg_next        = lg_reg;
        pbase_next     = pbase_reg;
        popen_next     = popen_reg;
        rowv_next      = rowv_reg;
        k_next         = k_reg;
        cont_open_next = cont_open_reg;
        rst_pend_next  = rst_pend_reg;
        emit_req       = 1'b0;
        emit_kind      = KIND_STATUS;

        unique case (state_reg)
            S_IDLE:
            begin
                if (midi.valid)
                begin
                    state_next = S_STATUS;
                    if (b == SYX_START)
                    begin
                        mode_next = MODE_OPEN;
                        hc_next   = 3'd0;
                        ff_next   = 1'b0;
                    end
                    if (mode_next == MODE_OPEN)
                    begin
                        if (ff_next)
                        begin
                            if (b < STATUS_BIT)
                            begin
                                if (uc_reg < 3'd7)
                                begin
                                    unpack_next[uc_reg] = b;
                                    uc_next = uc_reg + 3'd1;
                                end
                                else
                                begin
                                    // group byte: bit i is bit 7 of byte i
                                    for (int i = 0; i < 7; i++)
                                        unpack_next[i] = {b[i], unpack_reg[i][6:0]};
                                    uc_next    = 3'd0;
                                    step_next  = 3'd0;
                                    state_next = S_SUM;
                                end
                            end
                        end
                        else if (hc_next < 3'd4)
                        begin
                            // header byte 0 is always the start byte
                            case (hc_next)
                                3'd1:    h1_next = b;
                                3'd2:    h2_next = b;
                                3'd3:
                                begin
                                    if (h1_reg == HDR_ID1 && h2_reg == HDR_ID2 &&
                                        b == HDR_FLASH)
                                        ff_next = 1'b1;
                                    else if (h1_reg == HDR_ID1 && h2_reg == HDR_ID2 &&
                                             b == HDR_RESET)
                                    begin
                                        rst_pend_next = 1'b1;
                                        state_next    = S_ABORT;
                                    end
                                    else
                                        mode_next = MODE_IGNORE;
                                end
                                default: ;
                            endcase
                            hc_next = hc_next + 3'd1;
                        end
                    end
                    if (b == SYX_END)
                    begin
                        mode_next = MODE_IDLE;
                        hc_next   = 3'd0;
                        ff_next   = 1'b0;
                    end
                end
            end

            S_SUM:
            begin
                s1_next   = s1_mod;
                s2_next   = s2_mod;
                blk_next  = {sbyte, blk_reg[BLK_W-1:8]};
                bf_next   = bf_reg + 7'd1;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                    state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (bf_reg == 7'(BLOCK_LEN))
                begin
                    bf_next = 7'd0;
                    s1_next = 8'd0;
                    s2_next = 8'd0;
                    if (s1_reg != 8'd0 || s2_reg != 8'd0 || {1'b0, blk_id} != eid_reg)
                    begin
                        // failed block closes the message
                        mode_next  = MODE_IDLE;
                        hc_next    = 3'd0;
                        ff_next    = 1'b0;
                        state_next = S_ABORT;
                    end
                    else if (!tib_reg)
                        state_next = S_ENTER;
                    else
                        state_next = S_PLACE;
                end
                else
                    state_next = S_STATUS;
            end

            S_ABORT:
            begin
                uc_next = 3'd0;
                bf_next = 7'd0;
                s1_next = 8'd0;
                s2_next = 8'd0;
                if (tib_reg)
                begin
                    if (popen_reg)
                    begin
                        k_next         = '0;
                        cont_open_next = 1'b0;
                        state_next     = S_FL_RD;
                    end
                    else
                        state_next = S_RET;
                end
                else
                    state_next = rst_pend_reg ? S_RST : S_STATUS;
            end

            S_ENTER:
            begin
                emit_req  = 1'b1;
                emit_kind = KIND_ENTER;
                if (fire)
                begin
                    lg_next    = lg_clamped;
                    tib_next   = 1'b1;
                    state_next = S_PLACE;
                end
            end

            S_PLACE:
            begin
                if (!popen_reg)
                    state_next = S_OPEN;
                else if (blk_base != pbase_reg)
                begin
                    k_next         = '0;
                    cont_open_next = 1'b1;
                    state_next     = S_FL_RD;
                end
                else
                    state_next = S_WR0;
            end

            S_OPEN:
            begin
                pbase_next = blk_base;
                popen_next = 1'b1;
                rowv_next  = '0;
                state_next = S_WR0;
            end

            S_WR0:
            begin
                rowv_next[wr_row] = 1'b1;
                state_next        = S_WR1;
            end

            S_WR1:
            begin
                rowv_next[wr_row + ROW_W'(1)] = 1'b1;
                eid_next   = eid_reg + 17'd1;
                state_next = S_STATUS;
            end

            S_FL_RD:
                state_next = S_FL_EM;

            S_FL_EM:
            begin
                emit_req  = 1'b1;
                emit_kind = KIND_CHUNK;
                if (fire)
                begin
                    if (k_reg == last_k)
                    begin
                        popen_next = 1'b0;
                        state_next = cont_open_reg ? S_OPEN : S_RET;
                    end
                    else
                    begin
                        k_next     = k_reg + ROW_W'(1);
                        state_next = S_FL_RD;
                    end
                end
            end

            S_RET:
            begin
                emit_req  = 1'b1;
                emit_kind = KIND_RETURN;
                if (fire)
                begin
                    tib_next   = 1'b0;
                    eid_next   = 17'd0;
                    state_next = rst_pend_reg ? S_RST : S_STATUS;
                end
            end

            S_RST:
            begin
                emit_req  = 1'b1;
                emit_kind = KIND_SW_RST;
                if (fire)
                begin
                    rst_pend_next = 1'b0;
                    state_next    = S_STATUS;
                end
            end

            S_STATUS:
            begin
                emit_req  = 1'b1;
                emit_kind = KIND_STATUS;
                if (fire)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_IDLE;
            ff_reg        <= 1'b0;
            hc_reg        <= 3'd0;
            uc_reg        <= 3'd0;
            step_reg      <= 3'd0;
            s1_reg        <= 8'd0;
            s2_reg        <= 8'd0;
            bf_reg        <= 7'd0;
            eid_reg       <= 17'd0;
            tib_reg       <= 1'b0;
            lg_reg        <= LG_MAX;
            pbase_reg     <= 22'd0;
            popen_reg     <= 1'b0;
            rowv_reg      <= '0;
            k_reg         <= '0;
            cont_open_reg <= 1'b0;
            rst_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            ff_reg        <= ff_next;
            hc_reg        <= hc_next;
            uc_reg        <= uc_next;
            step_reg      <= step_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            bf_reg        <= bf_next;
            eid_reg       <= eid_next;
            tib_reg       <= tib_next;
            lg_reg        <= lg_next;
            pbase_reg     <= pbase_next;
            popen_reg     <= popen_next;
            rowv_reg      <= rowv_next;
            k_reg         <= k_next;
            cont_open_reg <= cont_open_next;
            rst_pend_reg  <= rst_pend_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        h1_reg     <= h1_next;
        h2_reg     <= h2_next;
        unpack_reg <= unpack_next;
        blk_reg    <= blk_next;
    end

    // ---------------- page memory ----------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR0)
            page_mem[wr_row] <= blk_reg[255:0];
        else if (state_reg == S_WR1)
            page_mem[wr_row + ROW_W'(1)] <= blk_reg[511:256];
        if (state_reg == S_FL_RD)
        begin
            mem_q <= page_mem[k_reg];
            rv_q  <= rowv_reg[k_reg];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (fire)
            ov_reg <= 1'b1;
        else if (result.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            okind_reg <= emit_kind;
            oaddr_reg <= (emit_kind == KIND_CHUNK) ? pbase_reg : 22'd0;
            oidx_reg  <= (emit_kind == KIND_CHUNK) ? 5'(k_reg) : 5'd0;
            odata_reg <= (emit_kind != KIND_CHUNK) ? 256'd0 : (rv_q ? mem_q : '1);
            oact_reg  <= (emit_kind == KIND_STATUS) && (ff_reg || tib_reg);
            olast_reg <= (emit_kind == KIND_STATUS);
        end
    end

    assign result.valid             = ov_reg;
    assign result.kind              = okind_reg;
    assign result.page_address      = oaddr_reg;
    assign result.chunk_index       = oidx_reg;
    assign result.chunk_bytes_0_7   = odata_reg[63:0];
    assign result.chunk_bytes_8_15  = odata_reg[127:64];
    assign result.chunk_bytes_16_23 = odata_reg[191:128];
    assign result.chunk_bytes_24_31 = odata_reg[255:192];
    assign result.active            = oact_reg;
    assign result.last              = olast_reg;

    // ---------------- config port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_PAGE_SIZE_LOG2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= LG_MAX;
        else if (cfg_wr)
            cfg_reg <= pwdata[3:0];
    end

    assign prdata = (paddr == REG_PAGE_SIZE_LOG2) ? {28'd0, cfg_reg} : 32'd0;

    // ---------------- assertions ----------------
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_page_needs_boot: assert property (@(posedge clk) disable iff (!rst_n)
        !tib_reg |-> !popen_reg)
        else $error("page open outside bootloader");

    a_eid_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !tib_reg |-> (eid_reg == 17'd0))
        else $error("block id nonzero outside bootloader");

    a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (bf_reg <= 7'd63))
        else $error("block fill overrun");

endmodule
